// ----- sv/svga_xrb_pkg.sv -----
package svga_xrb_pkg;

    // bus access kinds carried in s_tuser
    typedef enum logic [2:0] {
        FUNC_SEQ_RD  = 3'd0,
        FUNC_SEQ_WR  = 3'd1,
        FUNC_CRTC_RD = 3'd2,
        FUNC_CRTC_WR = 3'd3,
        FUNC_GC_RD   = 3'd4,
        FUNC_GC_WR   = 3'd5,
        FUNC_MEM_RD  = 3'd6,
        FUNC_MEM_WR  = 3'd7
    } func_t;

    // sequencer indices
    localparam logic [7:0] SEQ_UNLOCK     = 8'h05;
    localparam logic [7:0] SEQ_RAMDAC     = 8'h06;
    localparam logic [7:0] SEQ_MISC       = 8'h07;
    localparam logic [7:0] SEQ_VERT_OVF   = 8'h0a;
    localparam logic [7:0] SEQ_HORZ_OVF0  = 8'h0b;
    localparam logic [7:0] SEQ_HORZ_OVF1  = 8'h0c;
    localparam logic [7:0] SEQ_START_HIGH = 8'h0d;
    localparam logic [7:0] SEQ_PITCH      = 8'h0e;
    localparam logic [7:0] SEQ_BUS_VRAM   = 8'h14;

    // graphics controller indices
    localparam logic [7:0] GC_READ_BANK  = 8'h0b;
    localparam logic [7:0] GC_WRITE_BANK = 8'h0d;

    // CRTC fixed-read indices
    localparam logic [7:0] CRTC_ID0 = 8'h30;
    localparam logic [7:0] CRTC_ID1 = 8'h31;
    localparam logic [7:0] CRTC_ID2 = 8'h32;

    localparam logic [7:0] UNLOCK_KEY    = 8'h86;
    localparam logic [7:0] ID_UNLOCKED   = 8'ha1;
    localparam logic [7:0] ID_LOCKED     = 8'h21;
    localparam logic [7:0] TRUECOLOR_MSK = 8'h12;
    localparam logic [7:0] CRTC_ID0_VAL  = 8'h00;
    localparam logic [7:0] CRTC_ID1_VAL  = 8'h60;
    localparam logic [7:0] CRTC_ID2_VAL  = 8'h20;

    localparam logic [7:0] SCRATCH_BASE  = 8'h30;
    localparam int         SCRATCH_DEPTH = 208;

    localparam int         BANK_BYTES_DEF = 65536;
    localparam logic [6:0] VRAM_MB_RESET  = 7'd64;

    localparam int ADDR_W = 25;

endpackage

// ----- sv/svga_extended_register_bank.sv -----
// Extended register bank of an SVGA controller. Each word on the s_ side is
// one bus access (sequencer, CRTC or graphics register read/write, or a
// memory access) and yields exactly one result word on the m_ side, one
// word per clock while m_tready is high: the access is decoded and all flop
// registers updated in the cycle it is accepted, and the result is registered.
// The CRTC scratch area (indices 0x30..0xff) lives in a 208 x 8 synchronous
// RAM with a registered read port; the read is issued on acceptance and its
// data is muxed into the held result, so it stays valid while m_tready is low.
// Per-entry valid flops make unwritten scratch entries read as zero straight
// from reset, so there is no clearing pass. Memory accesses are translated to
// bank * BANK_BYTES + offset (kept to 25 bits) while any pixel format flag
// is set. vram_size_mb is written through cfg_*, which is always ready.
module svga_extended_register_bank #(
    parameter int BANK_BYTES = svga_xrb_pkg::BANK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,    // vram_size_mb

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // reg_index[7:0], wdata[15:8], mem_offset[32:16]
    input  logic [2:0]  s_tuser,     // func[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata      // rdata[7:0], linear_mode[8], linear_addr[33:9],
                                     // format_flags[37:34], pitch_high[41:38],
                                     // timing_changed[42]
);

    localparam int AW = svga_xrb_pkg::ADDR_W;

    // ---------------------------------------------------------------
    // input word unpacking
    // ---------------------------------------------------------------
    svga_xrb_pkg::func_t func;
    logic [7:0]  reg_index;
    logic [7:0]  wdata;
    logic [16:0] mem_offset;
    logic        acc;

    assign func       = svga_xrb_pkg::func_t'(s_tuser);
    assign reg_index  = s_tdata[7:0];
    assign wdata      = s_tdata[15:8];
    assign mem_offset = s_tdata[32:16];

    // ---------------------------------------------------------------
    // register state
    // ---------------------------------------------------------------
    logic [6:0] vram_mb_reg;
    logic       unlocked_reg,   unlocked_next;
    logic [7:0] ramdac_reg,     ramdac_next;
    logic [7:0] misc_reg,       misc_next;
    logic [7:0] vovf_reg,       vovf_next;
    logic [7:0] hovf0_reg,      hovf0_next;
    logic [7:0] hovf1_reg,      hovf1_next;
    logic [7:0] start_hi_reg,   start_hi_next;
    logic [3:0] pitch_reg,      pitch_next;
    logic [1:0] bus_w_reg,      bus_w_next;
    logic [7:0] rd_bank_reg,    rd_bank_next;
    logic [5:0] wr_bank_reg,    wr_bank_next;
    logic [3:0] fmt_reg,        fmt_next;

    // result register
    logic          out_valid_reg;
    logic [7:0]    rdata_reg,    rdata_next;
    logic          scr_rd_reg,   scr_rd_next;
    logic [AW-1:0] laddr_reg,    laddr_next;
    logic          pulse_reg,    pulse_next;

    // scratch RAM
    logic [7:0]               scr_mem [svga_xrb_pkg::SCRATCH_DEPTH];
    logic [svga_xrb_pkg::SCRATCH_DEPTH-1:0] scr_vld_reg;
    logic [7:0]               scr_q_reg;
    logic                     scr_q_vld_reg;
    logic                     in_scratch;
    logic [7:0]               scr_addr;

    logic [31:0] bank_sel;
    logic [31:0] bank_prod;
    logic [3:0]  fmt_tmp;
    logic [5:0]  vram_m1;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;

    assign in_scratch = (reg_index >= svga_xrb_pkg::SCRATCH_BASE);
    assign scr_addr   = reg_index - svga_xrb_pkg::SCRATCH_BASE;
    assign vram_m1    = vram_mb_reg[5:0] - 6'd1;   // modulo 64

    // linear address: bank times the bank size, one constant multiply
    assign bank_sel  = (func == svga_xrb_pkg::FUNC_MEM_RD) ? 32'(rd_bank_reg)
                                                            : 32'(wr_bank_reg);
    assign bank_prod = bank_sel * 32'(BANK_BYTES);

    // ---------------------------------------------------------------
    // decode and update
    // ---------------------------------------------------------------
    always_comb
    begin
        unlocked_next = unlocked_reg;
        ramdac_next   = ramdac_reg;
        misc_next     = misc_reg;
        vovf_next     = vovf_reg;
        hovf0_next    = hovf0_reg;
        hovf1_next    = hovf1_reg;
        start_hi_next = start_hi_reg;
        pitch_next    = pitch_reg;
        bus_w_next    = bus_w_reg;
        rd_bank_next  = rd_bank_reg;
        wr_bank_next  = wr_bank_reg;
        fmt_next      = fmt_reg;
        fmt_tmp       = fmt_reg;
        rdata_next    = 8'h00;
        scr_rd_next   = 1'b0;
        laddr_next    = '0;
        pulse_next    = 1'b0;

        unique case (func)
            svga_xrb_pkg::FUNC_SEQ_RD:
            begin
                unique case (reg_index)
                    svga_xrb_pkg::SEQ_UNLOCK:
                        rdata_next = unlocked_reg ? svga_xrb_pkg::ID_UNLOCKED
                                                  : svga_xrb_pkg::ID_LOCKED;
                    svga_xrb_pkg::SEQ_RAMDAC:     rdata_next = ramdac_reg;
                    svga_xrb_pkg::SEQ_MISC:       rdata_next = misc_reg;
                    svga_xrb_pkg::SEQ_VERT_OVF:   rdata_next = vovf_reg;
                    svga_xrb_pkg::SEQ_HORZ_OVF0:  rdata_next = hovf0_reg;
                    svga_xrb_pkg::SEQ_HORZ_OVF1:  rdata_next = hovf1_reg;
                    svga_xrb_pkg::SEQ_START_HIGH: rdata_next = start_hi_reg;
                    svga_xrb_pkg::SEQ_BUS_VRAM:   rdata_next = {bus_w_reg, vram_m1};
                    default:                      rdata_next = 8'h00;
                endcase
            end
            svga_xrb_pkg::FUNC_SEQ_WR:
            begin
                unique case (reg_index)
                    svga_xrb_pkg::SEQ_UNLOCK:
                        unlocked_next = (wdata == svga_xrb_pkg::UNLOCK_KEY);
                    svga_xrb_pkg::SEQ_RAMDAC:
                    begin
                        ramdac_next = wdata;
                        if (!wdata[1])
                        begin
                            fmt_next = 4'h0;
                        end
                        else
                        begin
                            fmt_tmp = {2'b00, fmt_reg[1] | wdata[3], fmt_reg[0] | wdata[2]};
                            if ((wdata & svga_xrb_pkg::TRUECOLOR_MSK)
                                == svga_xrb_pkg::TRUECOLOR_MSK)
                            begin
                                fmt_tmp[2] = misc_reg[2];
                                fmt_tmp[3] = !misc_reg[2];
                            end
                            fmt_next = fmt_tmp;
                        end
                    end
                    svga_xrb_pkg::SEQ_MISC:
                    begin
                        misc_next = wdata;
                        fmt_tmp   = {2'b00, fmt_reg[1:0]};
                        if ((ramdac_reg & svga_xrb_pkg::TRUECOLOR_MSK)
                            == svga_xrb_pkg::TRUECOLOR_MSK)
                        begin
                            fmt_tmp[2] = wdata[2];
                            fmt_tmp[3] = !wdata[2];
                        end
                        fmt_next = fmt_tmp;
                    end
                    svga_xrb_pkg::SEQ_VERT_OVF:
                    begin
                        vovf_next  = wdata;
                        pulse_next = 1'b1;
                    end
                    svga_xrb_pkg::SEQ_HORZ_OVF0:
                    begin
                        hovf0_next = wdata;
                        pulse_next = 1'b1;
                    end
                    svga_xrb_pkg::SEQ_HORZ_OVF1:
                    begin
                        hovf1_next = wdata;
                        pulse_next = 1'b1;
                    end
                    svga_xrb_pkg::SEQ_START_HIGH: start_hi_next = wdata;
                    svga_xrb_pkg::SEQ_PITCH:      pitch_next    = wdata[3:0];
                    svga_xrb_pkg::SEQ_BUS_VRAM:   bus_w_next    = wdata[7:6];
                    default:                      pulse_next    = 1'b0;
                endcase
            end
            svga_xrb_pkg::FUNC_CRTC_RD:
            begin
                unique case (reg_index)
                    svga_xrb_pkg::CRTC_ID0: rdata_next = svga_xrb_pkg::CRTC_ID0_VAL;
                    svga_xrb_pkg::CRTC_ID1: rdata_next = svga_xrb_pkg::CRTC_ID1_VAL;
                    svga_xrb_pkg::CRTC_ID2: rdata_next = svga_xrb_pkg::CRTC_ID2_VAL;
                    default:                scr_rd_next = in_scratch;
                endcase
            end
            svga_xrb_pkg::FUNC_CRTC_WR:
            begin
                rdata_next = 8'h00;   // RAM write handled below
            end
            svga_xrb_pkg::FUNC_GC_RD:
            begin
                if (reg_index == svga_xrb_pkg::GC_READ_BANK)
                    rdata_next = rd_bank_reg;
                else if (reg_index == svga_xrb_pkg::GC_WRITE_BANK)
                    rdata_next = {2'b00, wr_bank_reg};
            end
            svga_xrb_pkg::FUNC_GC_WR:
            begin
                if (reg_index == svga_xrb_pkg::GC_READ_BANK)
                    rd_bank_next = wdata;
                else if (reg_index == svga_xrb_pkg::GC_WRITE_BANK)
                    wr_bank_next = wdata[5:0];
            end
            svga_xrb_pkg::FUNC_MEM_RD,
            svga_xrb_pkg::FUNC_MEM_WR:
            begin
                if (fmt_reg != 4'h0)
                    laddr_next = bank_prod[AW-1:0] + AW'(mem_offset);
                else
                    laddr_next = AW'(mem_offset);
            end
            default:
            begin
                rdata_next = 8'h00;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control and register state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_mb_reg   <= svga_xrb_pkg::VRAM_MB_RESET;
            unlocked_reg  <= 1'b0;
            ramdac_reg    <= '0;
            misc_reg      <= '0;
            vovf_reg      <= '0;
            hovf0_reg     <= '0;
            hovf1_reg     <= '0;
            start_hi_reg  <= '0;
            pitch_reg     <= '0;
            bus_w_reg     <= '0;
            rd_bank_reg   <= '0;
            wr_bank_reg   <= '0;
            fmt_reg       <= '0;
            out_valid_reg <= 1'b0;
            scr_vld_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vram_mb_reg <= cfg_data;
            if (acc)
            begin
                unlocked_reg <= unlocked_next;
                ramdac_reg   <= ramdac_next;
                misc_reg     <= misc_next;
                vovf_reg     <= vovf_next;
                hovf0_reg    <= hovf0_next;
                hovf1_reg    <= hovf1_next;
                start_hi_reg <= start_hi_next;
                pitch_reg    <= pitch_next;
                bus_w_reg    <= bus_w_next;
                rd_bank_reg  <= rd_bank_next;
                wr_bank_reg  <= wr_bank_next;
                fmt_reg      <= fmt_next;
                if (func == svga_xrb_pkg::FUNC_CRTC_WR && in_scratch)
                    scr_vld_reg[scr_addr] <= 1'b1;
            end
            if (acc)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the word that caused it
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rdata_reg  <= rdata_next;
            scr_rd_reg <= scr_rd_next;
            laddr_reg  <= laddr_next;
            pulse_reg  <= pulse_next;
        end
    end

    // scratch RAM: write on a CRTC write, read issued on a CRTC read;
    // read data holds until the next accepted CRTC scratch read
    always_ff @(posedge clk)
    begin
        if (acc && func == svga_xrb_pkg::FUNC_CRTC_WR && in_scratch)
            scr_mem[scr_addr] <= wdata;
        if (acc && func == svga_xrb_pkg::FUNC_CRTC_RD && in_scratch)
        begin
            scr_q_reg     <= scr_mem[scr_addr];
            scr_q_vld_reg <= scr_vld_reg[scr_addr];
        end
    end

    // ---------------------------------------------------------------
    // output word
    // ---------------------------------------------------------------
    logic [7:0] rdata_out;

    assign rdata_out = scr_rd_reg ? (scr_q_vld_reg ? scr_q_reg : 8'h00) : rdata_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, pulse_reg, pitch_reg, fmt_reg, laddr_reg,
                       (fmt_reg != 4'h0), rdata_out};

endmodule
